[rtl/bclt_pkg.sv]
// Package for the binarize and center line track block.
// Field widths, configuration register indexes and shared structs; no dependencies.
package bclt_pkg;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 8;

    localparam logic [COL_W-1:0] MOVE_LIMIT = COL_W'(5);

    typedef enum logic [CIDX_W-1:0] {
        REG_NEAR_THRESHOLD = 3'd0,
        REG_FAR_THRESHOLD  = 3'd1,
        REG_NEAR_ROW_START = 3'd2,
        REG_SEED_ROW_LAST  = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] near_threshold;
        logic [PIX_W-1:0] far_threshold;
        logic [ROW_W-1:0] near_row_start;
        logic [ROW_W-1:0] seed_row_last;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             row_end;
        logic             frame_start;
    } pos_t;

endpackage

[rtl/bclt_position.sv]
// Raster position counters for the binarize and center line track block.
// Depends on bclt_pkg.
module bclt_position #(
    parameter int IMAGE_WIDTH  = 188,
    parameter int IMAGE_HEIGHT = 120
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           frame_start,
    output bclt_pkg::pos_t pos
);

    localparam logic [bclt_pkg::COL_W-1:0] LAST_COL = bclt_pkg::COL_W'(IMAGE_WIDTH - 1);
    localparam logic [bclt_pkg::ROW_W-1:0] LAST_ROW = bclt_pkg::ROW_W'(IMAGE_HEIGHT - 1);

    logic [bclt_pkg::COL_W-1:0] col_reg;
    logic [bclt_pkg::COL_W-1:0] col_next;
    logic [bclt_pkg::ROW_W-1:0] row_reg;
    logic [bclt_pkg::ROW_W-1:0] row_next;

    always_comb
    begin
        pos.frame_start = frame_start;
        pos.column      = frame_start ? '0 : col_reg;
        pos.row         = frame_start ? '0 : row_reg;
        pos.row_end     = (pos.column >= LAST_COL);
    end

    always_comb
    begin
        if (pos.row_end)
        begin
            col_next = '0;
            row_next = (pos.row >= LAST_ROW) ? '0 : pos.row + 1'b1;
        end
        else
        begin
            col_next = pos.column + 1'b1;
            row_next = pos.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= LAST_COL) && (row_reg <= LAST_ROW))
        else $error("raster position outside image");

endmodule

[rtl/bclt_binarize.sv]
// Threshold selection and pixel binarization.
// Depends on bclt_pkg.
module bclt_binarize (
    input  logic [bclt_pkg::PIX_W-1:0] pixel,
    input  logic [bclt_pkg::ROW_W-1:0] row,
    input  bclt_pkg::cfg_t             cfg,
    output logic                       black
);

    logic [bclt_pkg::PIX_W-1:0] thr;

    always_comb
    begin
        thr   = (row >= cfg.near_row_start) ? cfg.near_threshold : cfg.far_threshold;
        black = (pixel <= thr);
    end

endmodule

[rtl/bclt_tracker.sv]
// Edge search, reference edges and row midpoint.
// Depends on bclt_pkg.
module bclt_tracker #(
    parameter int IMAGE_WIDTH = 188
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  bclt_pkg::pos_t             pos,
    input  logic                       black,
    input  logic [bclt_pkg::ROW_W-1:0] seed_row_last,
    output logic [bclt_pkg::COL_W-1:0] mid
);

    localparam logic [bclt_pkg::COL_W-1:0] LAST_COL = bclt_pkg::COL_W'(IMAGE_WIDTH - 1);

    logic [bclt_pkg::COL_W-1:0] ref_left_reg, ref_left_next;
    logic [bclt_pkg::COL_W-1:0] ref_right_reg, ref_right_next;
    logic [bclt_pkg::COL_W-1:0] track_left_reg, track_left_next;
    logic [bclt_pkg::COL_W-1:0] track_right_reg, track_right_next;
    logic [bclt_pkg::COL_W-1:0] left_hold_reg, left_hold_next;
    logic [bclt_pkg::COL_W-1:0] right_hold_reg, right_hold_next;
    logic                       left_seen_reg, left_seen_next;
    logic                       right_seen_reg, right_seen_next;

    logic                       seed;
    logic                       lseen;
    logic                       rseen;
    logic [bclt_pkg::COL_W:0]   ref_sum;
    logic [bclt_pkg::COL_W:0]   mid_sum;
    logic [bclt_pkg::COL_W-1:0] center;
    logic [bclt_pkg::COL_W-1:0] seed_left;
    logic [bclt_pkg::COL_W-1:0] seed_right;
    logic [bclt_pkg::COL_W-1:0] move;
    logic                       adopt;

    always_comb
    begin
        seed    = (pos.row <= seed_row_last);
        lseen   = left_seen_reg & ~pos.frame_start;
        rseen   = right_seen_reg & ~pos.frame_start;
        ref_sum = {1'b0, ref_left_reg} + {1'b0, ref_right_reg};
        center  = ref_sum[bclt_pkg::COL_W:1];

        left_hold_next  = left_hold_reg;
        right_hold_next = right_hold_reg;
        left_seen_next  = lseen;
        right_seen_next = rseen;

        if (black)
        begin
            if (seed)
            begin
                if (!lseen)
                begin
                    left_hold_next = pos.column;
                    left_seen_next = 1'b1;
                end
                right_hold_next = pos.column;
                right_seen_next = 1'b1;
            end
            else
            begin
                if (pos.column <= center)
                begin
                    left_hold_next = pos.column;
                    left_seen_next = 1'b1;
                end
                if ((pos.column >= center) && !rseen)
                begin
                    right_hold_next = pos.column;
                    right_seen_next = 1'b1;
                end
            end
        end

        // candidate edges at row end
        seed_left        = left_seen_next  ? left_hold_next  : ref_left_reg;
        seed_right       = right_seen_next ? right_hold_next : ref_right_reg;
        track_left_next  = track_left_reg;
        track_right_next = track_right_reg;
        if (pos.row_end && !seed)
        begin
            if (left_seen_next)
                track_left_next = left_hold_next;
            if (right_seen_next)
                track_right_next = right_hold_next;
        end

        if (seed)
            mid_sum = {1'b0, seed_left} + {1'b0, seed_right};
        else
            mid_sum = {1'b0, track_left_next} + {1'b0, track_right_next};
        mid = mid_sum[bclt_pkg::COL_W:1];

        move  = (mid >= center) ? (mid - center) : (center - mid);
        adopt = ((track_left_next == '0) && (track_right_next == LAST_COL))
                || (move < bclt_pkg::MOVE_LIMIT);

        ref_left_next  = ref_left_reg;
        ref_right_next = ref_right_reg;
        if (pos.row_end)
        begin
            if (seed)
            begin
                ref_left_next  = seed_left;
                ref_right_next = seed_right;
            end
            else if (adopt)
            begin
                ref_left_next  = track_left_next;
                ref_right_next = track_right_next;
            end
            left_seen_next  = 1'b0;
            right_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_left_reg    <= '0;
            ref_right_reg   <= '0;
            track_left_reg  <= '0;
            track_right_reg <= '0;
            left_hold_reg   <= '0;
            right_hold_reg  <= '0;
            left_seen_reg   <= 1'b0;
            right_seen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            ref_left_reg    <= ref_left_next;
            ref_right_reg   <= ref_right_next;
            track_left_reg  <= track_left_next;
            track_right_reg <= track_right_next;
            left_hold_reg   <= left_hold_next;
            right_hold_reg  <= right_hold_next;
            left_seen_reg   <= left_seen_next;
            right_seen_reg  <= right_seen_next;
        end
    end

    a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pos.row_end |=> !left_seen_reg && !right_seen_reg)
        else $error("edge flags not cleared at row end");

endmodule

[rtl/binarize_and_center_line_track_top.sv]
// Top level of the binarize and center line track block.
// Path: input register, then result register, from request accept to result valid.
// Throughput: one pixel per cycle unless out_ready stalls; edge and midpoint logic is one stage.
// Reset (rst_n, async, active low) clears counters, edges, pipeline valids and sets
// thresholds to 128, near row start to 50, seed row last to 10.
// Depends on bclt_pkg, bclt_position, bclt_binarize, bclt_tracker.
module binarize_and_center_line_track_top #(
    parameter int IMAGE_WIDTH  = 188,
    parameter int IMAGE_HEIGHT = 120
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bclt_pkg::PIX_W-1:0]  pixel_in,
    input  logic                        frame_start,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        pixel_white,
    output logic                        mid_valid,
    output logic [bclt_pkg::ROW_W-1:0]  mid_row,
    output logic [bclt_pkg::COL_W-1:0]  mid_column,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bclt_pkg::CIDX_W-1:0] cfg_index,
    input  logic [bclt_pkg::CDAT_W-1:0] cfg_data
);

    bclt_pkg::cfg_t cfg_reg;

    logic                       in_valid_reg;
    logic [bclt_pkg::PIX_W-1:0] pixel_reg;
    logic                       frame_start_reg;

    logic                       out_valid_reg;
    logic                       pixel_white_reg;
    logic                       mid_valid_reg;
    logic [bclt_pkg::ROW_W-1:0] mid_row_reg;
    logic [bclt_pkg::COL_W-1:0] mid_column_reg;

    logic                       advance;
    logic                       black;
    logic [bclt_pkg::COL_W-1:0] mid;
    bclt_pkg::pos_t             pos;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold <= bclt_pkg::PIX_W'(128);
            cfg_reg.far_threshold  <= bclt_pkg::PIX_W'(128);
            cfg_reg.near_row_start <= bclt_pkg::ROW_W'(50);
            cfg_reg.seed_row_last  <= bclt_pkg::ROW_W'(10);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bclt_pkg::REG_NEAR_THRESHOLD: cfg_reg.near_threshold <= cfg_data;
                bclt_pkg::REG_FAR_THRESHOLD:  cfg_reg.far_threshold  <= cfg_data;
                bclt_pkg::REG_NEAR_ROW_START:
                    cfg_reg.near_row_start <= cfg_data[bclt_pkg::ROW_W-1:0];
                bclt_pkg::REG_SEED_ROW_LAST:
                    cfg_reg.seed_row_last  <= cfg_data[bclt_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pixel_reg       <= pixel_in;
            frame_start_reg <= frame_start;
        end
    end

    bclt_position #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .frame_start (frame_start_reg),
        .pos         (pos)
    );

    bclt_binarize u_binarize (
        .pixel (pixel_reg),
        .row   (pos.row),
        .cfg   (cfg_reg),
        .black (black)
    );

    bclt_tracker #(
        .IMAGE_WIDTH (IMAGE_WIDTH)
    ) u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .pos           (pos),
        .black         (black),
        .seed_row_last (cfg_reg.seed_row_last),
        .mid           (mid)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_white_reg <= ~black;
            mid_valid_reg   <= pos.row_end;
            mid_row_reg     <= pos.row_end ? pos.row : '0;
            mid_column_reg  <= pos.row_end ? mid : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_white = pixel_white_reg;
    assign mid_valid   = mid_valid_reg;
    assign mid_row     = mid_row_reg;
    assign mid_column  = mid_column_reg;

    a_mid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !mid_valid_reg |-> (mid_row_reg == '0) && (mid_column_reg == '0))
        else $error("midpoint fields set off row end");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(pixel_reg)
        && $stable(frame_start_reg))
        else $error("input register lost a stalled request");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request missing from result register");

endmodule
